@@ rtl/cta_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cta_pkg
// Types and constants shared by the calendar time advance unit.
// ----------------------------------------------------------------------------
// ----------------------------------------------------------------------------
package cta_pkg;

   localparam int unsigned MaxDays = 12;
   localparam logic [0:0] CsrAddrInterval = 1'b0;

   typedef struct packed {
      logic [11:0] in_year;
      logic [3:0]  in_month;
      logic [4:0]  in_day;
      logic [4:0]  in_hour;
      logic [5:0]  in_minute;
      logic [5:0]  in_second;
      logic [2:0]  in_weekday;
   } req_payload_type;

   typedef struct packed {
      logic [11:0] out_year;
      logic [3:0]  out_month;
      logic [4:0]  out_day;
      logic [4:0]  out_hour;
      logic [5:0]  out_minute;
      logic [5:0]  out_second;
      logic [2:0]  out_weekday;
   } rsp_payload_type;

   typedef struct packed {
      logic [11:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
   } date_type;

   function automatic logic is_leap(input logic [11:0] y);
      logic [5:0]  q100;
      logic [11:0] m100;
      q100 = 6'((25'(y) * 25'd5243) >> 19);
      m100 = 12'(q100) * 12'd100;
      return ((y[1:0] == 2'b00) && (m100 != y))
             || ((m100 == y) && (q100[1:0] == 2'b00));
   endfunction

   function automatic logic [2:0] wrap_weekday(input logic [4:0] s);
      logic [4:0] r;
      r = s;
      if (r >= 5'd14) begin
         r = r - 5'd14;
      end else if (r >= 5'd7) begin
         r = r - 5'd7;
      end
      return r[2:0];
   endfunction

   function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
      logic [4:0] d;
      case (m)
         4'd2:                      d = leap ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11:   d = 5'd30;
         default:                   d = 5'd31;
      endcase
      return d;
   endfunction

   function automatic date_type next_day(input date_type a, input logic leap);
      date_type r;
      r = a;
      if (a.day < month_days(a.month, leap)) begin
         r.day = a.day + 5'd1;
      end else begin
         r.day = 5'd1;
         if (a.month == 4'd0) begin
            r.month = 4'd1;
         end else if (a.month >= 4'd12) begin
            r.month = 4'd1;
            r.year  = a.year + 12'd1;
         end else begin
            r.month = a.month + 4'd1;
         end
      end
      return r;
   endfunction

endpackage
`default_nettype wire

@@ rtl/calendar_time_advance_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// calendar_time_advance_unit
// Adds a configured minute interval to a calendar time.
// ----------------------------------------------------------------------------
//  channel   direction  handshake
//  req_      in         req_valid / req_stall
//  rsp_      out        rsp_valid / rsp_stall
//  p*        in         APB write/read of interval_ff
//  Stages: two time stages, twelve day stages, one output stage.
//  One transfer per cycle; the whole pipe holds while rsp_stall is high and
//  the output register is full. Reset clears all valid bits and the interval.
// ----------------------------------------------------------------------------
module calendar_time_advance_unit (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire cta_pkg::req_payload_type  req_payload,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output cta_pkg::rsp_payload_type       rsp_payload,
   input  wire logic                      psel,
   input  wire logic                      penable,
   input  wire logic                      pwrite,
   input  wire logic [2:0]                paddr,
   input  wire logic [31:0]               pwdata,
   output logic [31:0]                    prdata,
   output logic                           pready
);
   localparam int unsigned N = cta_pkg::MaxDays;

   logic [13:0]       interval_ff;
   logic              advance;
   logic              tv;
   cta_pkg::date_type tdate;
   logic [4:0]        thour;
   logic [5:0]        tmin;
   logic [5:0]        tsec;
   logic [2:0]        twd;
   logic [3:0]        tdays;
   logic              tleap;

   logic              sv   [N+1];
   cta_pkg::date_type sd   [N+1];
   logic              sl   [N+1];
   logic [3:0]        sleft[N+1];

   logic [4:0]  h_ff [N];
   logic [5:0]  m_ff [N];
   logic [5:0]  s_ff [N];
   logic [2:0]  w_ff [N];

   assign pready    = 1'b1;
   assign prdata    = {18'd0, interval_ff};
   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff <= 14'd0;
      end else if (psel && penable && pwrite && (paddr[2] == cta_pkg::CsrAddrInterval)) begin
         interval_ff <= pwdata[13:0];
      end
   end

   cta_time_stage u_time (
      .clock, .reset, .advance,
      .in_valid(req_valid), .in_data(req_payload), .interval(interval_ff),
      .out_valid(tv), .out_date(tdate), .out_hour(thour), .out_minute(tmin),
      .out_second(tsec), .out_weekday(twd), .out_days(tdays), .out_leap(tleap)
   );

   assign sv[0]    = tv;
   assign sd[0]    = tdate;
   assign sl[0]    = tleap;
   assign sleft[0] = tdays;

   for (genvar g = 0; g < N; g++) begin : g_day
      cta_day_stage u_day (
         .clock, .reset, .advance,
         .in_valid(sv[g]), .in_date(sd[g]), .in_leap(sl[g]), .in_left(sleft[g]),
         .out_valid(sv[g+1]), .out_date(sd[g+1]), .out_leap(sl[g+1]),
         .out_left(sleft[g+1])
      );
      always_ff @(posedge clock) begin
         if (advance) begin
            h_ff[g] <= (g == 0) ? thour : h_ff[(g == 0) ? 0 : g-1];
            m_ff[g] <= (g == 0) ? tmin  : m_ff[(g == 0) ? 0 : g-1];
            s_ff[g] <= (g == 0) ? tsec  : s_ff[(g == 0) ? 0 : g-1];
            w_ff[g] <= (g == 0) ? cta_pkg::wrap_weekday(5'(twd) + 5'(tdays))
                                : w_ff[(g == 0) ? 0 : g-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else if (advance) begin
         rsp_valid <= sv[N];
      end
      if (advance) begin
         rsp_payload <= '{sd[N].year, sd[N].month, sd[N].day,
                          h_ff[N-1], m_ff[N-1], s_ff[N-1], w_ff[N-1]};
      end
   end

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("result dropped under stall");
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.out_hour < 5'd24 && rsp_payload.out_minute < 6'd60
                    && rsp_payload.out_weekday < 3'd7)
      else $error("time field out of range");
   a_stall: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without cause");
endmodule
`default_nettype wire

@@ rtl/cta_time_stage.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cta_time_stage
// Splits minute total into minute, hour and carried days over two stages.
// ----------------------------------------------------------------------------
// ----------------------------------------------------------------------------
module cta_time_stage (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      advance,
   input  wire logic                      in_valid,
   input  wire cta_pkg::req_payload_type  in_data,
   input  wire logic [13:0]               interval,
   output logic                           out_valid,
   output cta_pkg::date_type              out_date,
   output logic [4:0]                     out_hour,
   output logic [5:0]                     out_minute,
   output logic [5:0]                     out_second,
   output logic [2:0]                     out_weekday,
   output logic [3:0]                     out_days,
   output logic                           out_leap
);
   logic                         v1_ff;
   cta_pkg::req_payload_type     p1_ff;
   logic [8:0]                   hrs1_ff;
   logic [5:0]                   min1_ff;
   logic [14:0]                  tot;
   logic [8:0]                   hq;
   logic [13:0]                  hrem;
   logic [8:0]                   th;
   logic [3:0]                   dq;

   always_comb begin
      tot  = {1'b0, interval} + {9'd0, in_data.in_minute};
      hq   = 9'((25'(tot) * 25'd1092) >> 16);
      hrem = 14'(tot - 15'(hq) * 15'd60);
      if (hrem >= 14'd60) begin
         hq   = hq + 9'd1;
         hrem = hrem - 14'd60;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= in_valid;
      end
      if (advance) begin
         p1_ff   <= in_data;
         hrs1_ff <= hq;
         min1_ff <= hrem[5:0];
      end
   end

   always_comb begin
      th = hrs1_ff + {4'd0, p1_ff.in_hour};
      dq = 4'((16'(th) * 16'd171) >> 12);
      if (9'(th - 9'(dq * 9'd24)) >= 9'd24) begin
         dq = dq + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid <= 1'b0;
      end else if (advance) begin
         out_valid <= v1_ff;
      end
      if (advance) begin
         out_date    <= '{p1_ff.in_year, p1_ff.in_month, p1_ff.in_day};
         out_hour    <= 5'(th - 9'(dq * 9'd24));
         out_minute  <= min1_ff;
         out_second  <= p1_ff.in_second;
         out_weekday <= p1_ff.in_weekday;
         out_days    <= dq;
         out_leap    <= cta_pkg::is_leap(p1_ff.in_year);
      end
   end
endmodule
`default_nettype wire

@@ rtl/cta_day_stage.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cta_day_stage
// One pipeline stage that steps the date by one day if days remain.
// ----------------------------------------------------------------------------
// ----------------------------------------------------------------------------
module cta_day_stage (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               advance,
   input  wire logic               in_valid,
   input  wire cta_pkg::date_type  in_date,
   input  wire logic               in_leap,
   input  wire logic [3:0]         in_left,
   output logic                    out_valid,
   output cta_pkg::date_type       out_date,
   output logic                    out_leap,
   output logic [3:0]              out_left
);
   cta_pkg::date_type stepped;
   logic              step_leap;

   always_comb begin
      stepped   = cta_pkg::next_day(in_date, in_leap);
      step_leap = (stepped.year != in_date.year) ? cta_pkg::is_leap(stepped.year) : in_leap;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid <= 1'b0;
      end else if (advance) begin
         out_valid <= in_valid;
      end
      if (advance) begin
         if (in_left != 4'd0) begin
            out_date <= stepped;
            out_leap <= step_leap;
            out_left <= in_left - 4'd1;
         end else begin
            out_date <= in_date;
            out_leap <= in_leap;
            out_left <= in_left;
         end
      end
   end
endmodule
`default_nettype wire

@@ bench/cta_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cta_checker
// Watches the request and response channels of the calendar time advance
// unit, predicts each response from the accepted request and the current
// interval, and compares the responses in order.
// ----------------------------------------------------------------------------
module cta_checker (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_stall,
   input  cta_pkg::req_payload_type req_payload,
   input  logic                     rsp_valid,
   input  logic                     rsp_stall,
   input  cta_pkg::rsp_payload_type rsp_payload,
   input  logic [13:0]              interval,
   output int                       fail_count,
   output int                       pending_count
);
   cta_pkg::rsp_payload_type expected_times[$];

   function automatic bit leap_of(input int unsigned y);
      return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
   endfunction

   function automatic int unsigned length_of(input int unsigned m, input int unsigned y);
      int unsigned lens[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
      if (m < 1 || m > 12) return 31;
      if (m == 2 && leap_of(y)) return 29;
      return lens[m - 1];
   endfunction

   function automatic cta_pkg::rsp_payload_type advance_time(
      input cta_pkg::req_payload_type t, input logic [13:0] minutes);
      cta_pkg::rsp_payload_type r;
      int unsigned yr, mo, dy, tot_min, tot_hr, days;
      yr = t.in_year;
      mo = t.in_month;
      dy = t.in_day;
      tot_min = t.in_minute + minutes;
      tot_hr = t.in_hour + tot_min / 60;
      days = tot_hr / 24;
      for (int unsigned i = 0; i < days; i++) begin
         if (dy < length_of(mo, yr)) begin
            dy++;
         end else begin
            dy = 1;
            if (mo == 0) begin
               mo = 1;
            end else if (mo >= 12) begin
               mo = 1;
               yr = (yr + 1) & 12'hFFF;
            end else begin
               mo++;
            end
         end
      end
      r.out_year = yr[11:0];
      r.out_month = mo[3:0];
      r.out_day = dy[4:0];
      r.out_hour = 5'(tot_hr % 24);
      r.out_minute = 6'(tot_min % 60);
      r.out_second = t.in_second;
      r.out_weekday = 3'((t.in_weekday + days) % 7);
      return r;
   endfunction

   always @(posedge clock) begin
      cta_pkg::rsp_payload_type exp_t;
      if (reset) begin
         fail_count <= 0;
         pending_count <= 0;
         expected_times.delete();
      end else begin
         if (req_valid && !req_stall)
            expected_times.push_back(advance_time(req_payload, interval));
         if (rsp_valid && !rsp_stall) begin
            if (expected_times.size() == 0) begin
               fail_count <= fail_count + 1;
               if (fail_count < 10) $display("unexpected response %h", rsp_payload);
            end else begin
               exp_t = expected_times.pop_front();
               if (exp_t !== rsp_payload) begin
                  fail_count <= fail_count + 1;
                  if (fail_count < 10)
                     $display("mismatch: expected %0d-%0d-%0d %0d:%0d:%0d wd%0d,",
                        exp_t.out_year, exp_t.out_month, exp_t.out_day, exp_t.out_hour,
                        exp_t.out_minute, exp_t.out_second, exp_t.out_weekday,
                        " got %0d-%0d-%0d %0d:%0d:%0d wd%0d",
                        rsp_payload.out_year, rsp_payload.out_month, rsp_payload.out_day,
                        rsp_payload.out_hour, rsp_payload.out_minute,
                        rsp_payload.out_second, rsp_payload.out_weekday);
               end
            end
         end
         pending_count <= expected_times.size();
      end
   end
endmodule

@@ bench/tb_calendar_time_advance_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_calendar_time_advance_unit
// Drives calendar times through the unit over several interval settings and
// stall patterns; the checker predicts and compares every response.
// ----------------------------------------------------------------------------
module tb_calendar_time_advance_unit;

   localparam int Latency = 15;
   localparam int WatchdogLimit = 20000;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   cta_pkg::req_payload_type req_payload;
   logic                     rsp_valid;
   logic                     rsp_stall;
   cta_pkg::rsp_payload_type rsp_payload;
   logic                     psel, penable, pwrite;
   logic [2:0]               paddr;
   logic [31:0]              pwdata;
   logic [31:0]              prdata;
   logic                     pready;
   logic [13:0]              interval;
   int                       fail_count;
   int                       pending_count;
   int                       send_idle_pct;
   int                       recv_stall_pct;
   bit                       hold_rsp;
   int                       quiet_cycles;

   calendar_time_advance_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   cta_checker checker_i (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload),
      .interval(interval), .fail_count(fail_count), .pending_count(pending_count)
   );

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   // receiver stall
   always @(negedge clock) begin
      if (reset) rsp_stall <= 0;
      else rsp_stall <= hold_rsp || ($urandom_range(99) < recv_stall_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WatchdogLimit) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   task automatic write_interval(input logic [13:0] value);
      @(negedge clock);
      psel <= 1; pwrite <= 1; paddr <= {cta_pkg::CsrAddrInterval, 2'b00};
      pwdata <= 32'(value);
      @(negedge clock);
      penable <= 1;
      @(posedge clock);
      interval <= value;
      @(negedge clock);
      psel <= 0; penable <= 0; pwrite <= 0;
   endtask

   task automatic drain;
      @(negedge clock);
      req_valid <= 0;
      while (pending_count != 0) @(posedge clock);
      repeat (Latency + 2) @(posedge clock);
   endtask

   task automatic send_time(input cta_pkg::req_payload_type t);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid <= 1;
      req_payload <= t;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   function automatic cta_pkg::req_payload_type random_time(input bit wild);
      cta_pkg::req_payload_type t;
      t = 41'({$urandom, $urandom});
      if (!wild) begin
         t.in_year = ($urandom_range(3) == 0) ? 12'($urandom_range(4095))
                   : 12'($urandom_range(1896, 2404));
         t.in_month = 4'($urandom_range(1, 12));
         t.in_day = ($urandom_range(2) == 0) ? 5'($urandom_range(26, 31))
                  : 5'($urandom_range(1, 28));
         t.in_hour = 5'($urandom_range(23));
         t.in_minute = 6'($urandom_range(59));
         t.in_second = 6'($urandom_range(59));
         t.in_weekday = 3'($urandom_range(6));
      end
      return t;
   endfunction

   function automatic cta_pkg::req_payload_type make_time(input int y, m, d, h, mi, s, w);
      cta_pkg::req_payload_type t;
      t = {12'(y), 4'(m), 5'(d), 5'(h), 6'(mi), 6'(s), 3'(w)};
      return t;
   endfunction

   initial begin
      logic [13:0] settings[8] = '{14'd10080, 14'd0, 14'd16383, 14'd1, 14'd1440,
                                   14'd59, 14'd4321, 14'd0};
      int pct_send[4] = '{0, 80, 0, 20};
      int pct_recv[4] = '{0, 0, 80, 20};
      reset = 1; req_valid = 0; req_payload = '0; psel = 0; penable = 0; pwrite = 0;
      paddr = '0; pwdata = '0; interval = '0; send_idle_pct = 0; recv_stall_pct = 0;
      hold_rsp = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed
      write_interval(14'd10080);
      send_time(make_time(4095, 12, 31, 23, 59, 59, 6));
      send_time(make_time(2024, 2, 28, 0, 0, 0, 0));
      send_time(make_time(2000, 2, 29, 12, 30, 1, 3));
      send_time(make_time(1900, 2, 27, 5, 5, 5, 2));
      send_time(make_time(0, 2, 28, 0, 0, 0, 7));
      send_time(make_time(2023, 0, 31, 31, 63, 63, 7));
      send_time(make_time(2023, 13, 31, 0, 0, 0, 1));
      send_time(make_time(2023, 15, 30, 0, 0, 0, 1));
      send_time(make_time(2023, 4, 31, 0, 0, 0, 1));
      send_time(make_time(2023, 6, 0, 0, 0, 0, 1));
      send_time(make_time(2023, 11, 30, 31, 63, 0, 4));
      drain();
      write_interval(14'd16383);
      send_time(make_time(4095, 12, 25, 31, 63, 63, 7));
      send_time(make_time(2100, 2, 20, 0, 0, 0, 0));
      drain();
      write_interval(14'd0);
      send_time(make_time(0, 0, 0, 0, 0, 0, 0));
      send_time(make_time(4095, 15, 31, 31, 63, 63, 7));
      send_time(make_time(2023, 14, 0, 23, 59, 0, 6));
      drain();

      // random phases
      for (int p = 0; p < 8; p++) begin
         write_interval((p == 4) ? 14'($urandom_range(16383)) : settings[p]);
         send_idle_pct = pct_send[p % 4];
         recv_stall_pct = pct_recv[p % 4];
         if (p == 6) begin
            fork
               begin
                  hold_rsp = 1;
                  repeat (60) @(posedge clock);
                  hold_rsp = 0;
               end
            join_none
         end
         for (int i = 0; i < 105; i++) begin
            send_time(random_time($urandom_range(9) == 0));
            if (i == 50) drain();
         end
         drain();
      end

      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end
endmodule
